>>> hdl/met_pkg.sv
`default_nettype none

package met_pkg;

  // encoder geometry
  localparam int unsigned COUNTS_PER_REV = 8192;
  localparam int unsigned CPR_BITS       = $clog2(COUNTS_PER_REV);

  localparam logic signed [14:0] REV_COUNTS  = 15'sd8192;
  localparam logic signed [14:0] HALF_COUNTS = 15'sd4096;

  // degrees in q13
  localparam logic signed [37:0] DEG_Q13_PER_TURN  = 38'sd2949120;
  localparam logic signed [22:0] DEG_Q13_PER_COUNT = 23'sd360;

  // torque scaling: 9549 * 24
  localparam logic [17:0] TORQUE_GAIN = 18'd229176;
  localparam logic [4:0]  CUR_GAIN    = 5'd20;
  localparam int unsigned CUR_SHIFT   = 14;

  localparam logic [7:0] FRAME_CNT_MAX = 8'd255;
  localparam logic [7:0] BIAS_FRAMES_RST = 8'd2;

  // iterative divider
  localparam int unsigned DIV_W     = 24;
  localparam int unsigned DIV_CNT_W = 5;

  typedef struct packed {
    logic accept;
    logic eval;
    logic acc;
    logic mul;
    logic div_step;
    logic load;
  } met_cmd_t;

  typedef struct packed {
    logic process;
    logic out_free;
  } met_sts_t;

endpackage

`default_nettype wire

>>> hdl/motor_encoder_feedback_tracker_unit.sv
// channel   dir  handshake                     tdata / tuser
// s_axis    in   s_axis_tvalid/s_axis_tready   frame fields / action
// m_axis    out  m_axis_tvalid/m_axis_tready   tracker result / torque_invalid
// cfg       in   cfg_we_i (no wait)            bias_frames
//
// a processed frame gives one result beat; the next input beat is taken only once
// its result is loaded; restart and bias frames give no beat
// the torque estimate comes from a radix-2 divider (24 steps)
// one output register: the next beat is accepted while a result waits,
// the result is loaded once the output register is free
// reset clears the tracker state and sets bias_frames to 2
`default_nettype none

module motor_encoder_feedback_tracker_unit #(
  parameter int unsigned RATE_TAPS = 6
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          cfg_we_i,
  input  wire  [7:0]   cfg_wdata_i,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // angle_raw[12:0], speed_rpm[28:13], current_raw[44:29], temp_raw[52:45]
  input  wire  [55:0]  s_axis_tdata,
  // action[0]
  input  wire  [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // position_count[29:0], turns[45:30], angle_q13[83:46], step_rate[97:84],
  // filtered_rate[111:98], speed_out[127:112], scaled_current[134:128],
  // torque_estimate[159:135], temperature[167:160]
  output logic [167:0] m_axis_tdata,
  // torque_invalid[0]
  output logic [0:0]   m_axis_tuser
);

  met_pkg::met_cmd_t cmd;
  met_pkg::met_sts_t sts;

  met_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  met_dp #(
    .RATE_TAPS (RATE_TAPS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_action_i     (s_axis_tuser[0]),
    .in_angle_i      (s_axis_tdata[12:0]),
    .in_speed_i      (s_axis_tdata[28:13]),
    .in_current_i    (s_axis_tdata[44:29]),
    .in_temp_i       (s_axis_tdata[52:45]),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_position_o  (m_axis_tdata[29:0]),
    .out_turns_o     (m_axis_tdata[45:30]),
    .out_angle_q13_o (m_axis_tdata[83:46]),
    .out_step_o      (m_axis_tdata[97:84]),
    .out_filt_o      (m_axis_tdata[111:98]),
    .out_speed_o     (m_axis_tdata[127:112]),
    .out_tq_o        (m_axis_tdata[134:128]),
    .out_est_o       (m_axis_tdata[159:135]),
    .out_invalid_o   (m_axis_tuser[0]),
    .out_temp_o      (m_axis_tdata[167:160])
  );

endmodule

`default_nettype wire

>>> hdl/met_ctrl.sv
`default_nettype none

module met_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  met_pkg::met_sts_t sts_i,
  output met_pkg::met_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam logic [met_pkg::DIV_CNT_W-1:0] DIV_LAST =
    met_pkg::DIV_CNT_W'(met_pkg::DIV_W - 1);

  logic [2:0] state_q, state_d;
  logic [met_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.process ? S_ACC : S_IDLE;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        cnt_d     = '0;
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/met_dp.sv
`default_nettype none

module met_dp #(
  parameter int unsigned RATE_TAPS = 6
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  met_pkg::met_cmd_t cmd_i,
  output met_pkg::met_sts_t sts_o,
  input  wire               cfg_we_i,
  input  wire  [7:0]        cfg_wdata_i,
  input  wire               in_action_i,
  input  wire  [12:0]       in_angle_i,
  input  wire  [15:0]       in_speed_i,
  input  wire  [15:0]       in_current_i,
  input  wire  [7:0]        in_temp_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output logic [29:0]       out_position_o,
  output logic [15:0]       out_turns_o,
  output logic [37:0]       out_angle_q13_o,
  output logic [13:0]       out_step_o,
  output logic [13:0]       out_filt_o,
  output logic [15:0]       out_speed_o,
  output logic [6:0]        out_tq_o,
  output logic [24:0]       out_est_o,
  output logic              out_invalid_o,
  output logic [7:0]        out_temp_o
);

  localparam int unsigned IDX_W  = (RATE_TAPS > 1) ? $clog2(RATE_TAPS) : 1;
  localparam int unsigned SUM_W  = 14 + $clog2(RATE_TAPS);
  localparam int unsigned PROD_W = SUM_W + 25;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RATE_TAPS - 1);
  // ceil(2^24 / taps): exact truncated quotient for sums below 2^17
  localparam logic [24:0] FILT_RECIP = 25'((2 ** 24 + RATE_TAPS - 1) / RATE_TAPS);

  localparam int unsigned DW = met_pkg::DIV_W;

  // captured frame
  logic        action_q;
  logic [12:0] angle_q;
  logic signed [15:0] speed_q;
  logic signed [15:0] current_q;
  logic [7:0]  temp_q;

  // tracker state
  logic [7:0]  bias_frames_q;
  logic [7:0]  frame_cnt_q;
  logic [12:0] zero_bias_q;
  logic [12:0] prev_angle_q;
  logic signed [15:0] turn_q;
  logic signed [13:0] hist_q [RATE_TAPS];
  logic [IDX_W-1:0]   idx_q;
  logic signed [SUM_W-1:0] sum_q;

  // per-item working registers
  logic signed [13:0] step_q;
  logic [5:0]          tq_mag_q;
  logic                tq_neg_q;
  logic signed [22:0]  aq_lo_q;
  logic signed [37:0]  aq_hi_q;
  logic signed [37:0]  aq_q;
  logic signed [13:0]  filt_q;
  logic                est_neg_q;
  logic [16:0]         rem_q;
  logic [DW-1:0]       quo_q;
  logic [15:0]         divisor_q;

  // frame count and bias decision
  logic [7:0] cnt_next;
  logic       is_bias;
  assign cnt_next = (frame_cnt_q == met_pkg::FRAME_CNT_MAX) ? frame_cnt_q : frame_cnt_q + 1'b1;
  assign is_bias  = (cnt_next <= bias_frames_q);

  assign sts_o.process  = !action_q && !is_bias;
  assign sts_o.out_free = !out_valid_o || out_ready_i;

  // unwrap
  logic signed [14:0] diff;
  logic signed [14:0] step_full;
  logic               wrap_up;
  logic               wrap_dn;
  assign diff    = signed'({2'b00, angle_q}) - signed'({2'b00, prev_angle_q});
  assign wrap_up = (diff < -met_pkg::HALF_COUNTS);
  assign wrap_dn = (diff > met_pkg::HALF_COUNTS);
  always_comb begin
    step_full = diff;
    if (wrap_up) begin
      step_full = diff + met_pkg::REV_COUNTS;
    end else if (wrap_dn) begin
      step_full = diff - met_pkg::REV_COUNTS;
    end
  end

  // torque current magnitude
  logic [16:0] cur_mag;
  logic [21:0] cur_scaled;
  assign cur_mag    = current_q[15] ? 17'(-{current_q[15], current_q})
                                    : 17'({1'b0, current_q});
  assign cur_scaled = 22'(cur_mag) * 22'(met_pkg::CUR_GAIN);

  // angle in q13
  logic signed [13:0] bias_diff;
  logic signed [37:0] turn_ext;
  assign bias_diff = signed'({1'b0, angle_q}) - signed'({1'b0, zero_bias_q});
  assign turn_ext  = 38'(turn_q);

  // moving average magnitude
  logic [SUM_W-1:0]  sum_mag;
  logic [PROD_W-1:0] filt_prod;
  logic [13:0]       filt_mag;
  assign sum_mag   = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign filt_prod = PROD_W'(sum_mag) * PROD_W'(FILT_RECIP);
  assign filt_mag  = filt_prod[24 +: 14];

  // divider step
  logic [16:0] rem_shift;
  logic [16:0] rem_trial;
  logic        rem_ge;
  assign rem_shift = {rem_q[15:0], quo_q[DW-1]};
  assign rem_ge    = (rem_shift >= {1'b0, divisor_q});
  assign rem_trial = rem_shift - {1'b0, divisor_q};

  // output assembly
  logic signed [29:0] position;
  logic signed [24:0] est_signed;
  assign position   = (30'(turn_q) <<< met_pkg::CPR_BITS) + signed'(30'({17'b0, angle_q}));
  assign est_signed = est_neg_q ? 25'(-{1'b0, quo_q}) : 25'({1'b0, quo_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_frames_q <= met_pkg::BIAS_FRAMES_RST;
      frame_cnt_q   <= '0;
      zero_bias_q   <= '0;
      prev_angle_q  <= '0;
      turn_q        <= '0;
      idx_q         <= '0;
      sum_q         <= '0;
      for (int i = 0; i < RATE_TAPS; i++) begin
        hist_q[i] <= '0;
      end
      out_valid_o   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        bias_frames_q <= cfg_wdata_i;
      end
      if (cmd_i.eval) begin
        if (action_q) begin
          frame_cnt_q <= '0;
        end else begin
          frame_cnt_q <= cnt_next;
          prev_angle_q <= angle_q;
          if (is_bias) begin
            zero_bias_q <= angle_q;
          end else begin
            if (wrap_up && turn_q != 16'sh7fff) begin
              turn_q <= turn_q + 16'sd1;
            end else if (wrap_dn && turn_q != -16'sh8000) begin
              turn_q <= turn_q - 16'sd1;
            end
          end
        end
      end
      if (cmd_i.acc) begin
        hist_q[idx_q] <= step_q;
        sum_q <= sum_q + SUM_W'(step_q) - SUM_W'(hist_q[idx_q]);
        idx_q <= (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
      end
      if (cmd_i.load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      action_q  <= in_action_i;
      angle_q   <= in_angle_i;
      speed_q   <= in_speed_i;
      current_q <= in_current_i;
      temp_q    <= in_temp_i;
    end
    if (cmd_i.eval) begin
      step_q <= step_full[13:0];
    end
    if (cmd_i.acc) begin
      tq_mag_q <= cur_scaled[met_pkg::CUR_SHIFT +: 6];
      tq_neg_q <= current_q[15];
      aq_lo_q  <= 23'(bias_diff) * met_pkg::DEG_Q13_PER_COUNT;
      aq_hi_q  <= turn_ext * met_pkg::DEG_Q13_PER_TURN;
    end
    if (cmd_i.mul) begin
      aq_q      <= aq_hi_q + 38'(aq_lo_q);
      filt_q    <= sum_q[SUM_W-1] ? -signed'(filt_mag) : signed'(filt_mag);
      quo_q     <= DW'(24'(tq_mag_q) * 24'(met_pkg::TORQUE_GAIN));
      rem_q     <= '0;
      divisor_q <= speed_q[15] ? 16'(-speed_q) : 16'(speed_q);
      est_neg_q <= tq_neg_q ^ speed_q[15];
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_ge ? rem_trial : rem_shift;
      quo_q <= {quo_q[DW-2:0], rem_ge};
    end
    if (cmd_i.load) begin
      out_position_o  <= position;
      out_turns_o     <= turn_q;
      out_angle_q13_o <= aq_q;
      out_step_o      <= step_q;
      out_filt_o      <= filt_q;
      out_speed_o     <= speed_q;
      out_tq_o        <= tq_neg_q ? 7'(-{1'b0, tq_mag_q}) : {1'b0, tq_mag_q};
      out_est_o       <= (speed_q == '0) ? '0 : est_signed;
      out_invalid_o   <= (speed_q == '0);
      out_temp_o      <= temp_q;
    end
  end

endmodule

`default_nettype wire

>>> bench/motor_encoder_feedback_tracker_unit_tb.sv
module motor_encoder_feedback_tracker_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REV_COUNTS     = 8192;
  localparam int HALF_REV       = 4096;
  localparam int RATE_TAPS      = 6;
  localparam longint DEG_PER_TURN = 2949120;
  localparam int SETTLE_CYCLES  = 40;
  localparam int LONG_HOLD      = 600;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_FRAMES   = 54;

  typedef enum logic {
    ACT_FEEDBACK = 1'b0,
    ACT_RESTART  = 1'b1
  } frame_action_e;

  typedef struct {
    frame_action_e      action;
    logic [12:0]        angle;
    logic signed [15:0] speed;
    logic signed [15:0] current;
    logic [7:0]         temp;
  } enc_frame_t;

  // laid out as {tuser, tdata}, msb first
  typedef struct packed {
    logic               invalid;
    logic [7:0]         temperature;
    logic signed [24:0] torque_est;
    logic signed [6:0]  torque_cur;
    logic signed [15:0] speed;
    logic signed [13:0] filt_rate;
    logic signed [13:0] step_rate;
    logic signed [37:0] angle_q13;
    logic signed [15:0] turns;
    logic signed [29:0] position;
  } track_result_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_we_i = 1'b0;
  logic [7:0]    cfg_wdata_i = 8'd0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [55:0]   s_axis_tdata = 56'd0;
  logic [0:0]    s_axis_tuser = 1'b0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [167:0]  m_axis_tdata;
  logic [0:0]    m_axis_tuser;

  motor_encoder_feedback_tracker_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // tracker copy
  int bias_cfg = met_pkg::BIAS_FRAMES_RST;
  int zero_bias;
  int prev_angle;
  int turn_cnt;
  int rate_hist[RATE_TAPS];
  int hist_idx;
  int frame_cnt;

  enc_frame_t    feedback_frames_q[$];
  track_result_t tracker_results_q[$];
  int            mismatches;
  int            gen_angle;

  task automatic track_frame(input enc_frame_t f);
    int ang;
    int diff;
    int step_v;
    int rate_sum;
    longint cur_q;
    longint est_v;
    track_result_t r;
    ang = f.angle;
    if (f.action == ACT_RESTART) begin
      frame_cnt = 0;
      return;
    end
    if (frame_cnt < 255) frame_cnt++;
    if (frame_cnt <= bias_cfg) begin
      zero_bias = ang;
      prev_angle = ang;
      return;
    end
    diff = ang - prev_angle;
    prev_angle = ang;
    if (diff < -HALF_REV) begin
      if (turn_cnt < 32767) turn_cnt++;
      step_v = diff + REV_COUNTS;
    end else if (diff > HALF_REV) begin
      if (turn_cnt > -32768) turn_cnt--;
      step_v = diff - REV_COUNTS;
    end else begin
      step_v = diff;
    end
    rate_hist[hist_idx] = step_v;
    hist_idx = (hist_idx + 1) % RATE_TAPS;
    rate_sum = 0;
    foreach (rate_hist[i]) rate_sum += rate_hist[i];
    cur_q = longint'(f.current) * 20 / 16384;
    est_v = (f.speed == 0) ? 0 : 229176 * cur_q / longint'(f.speed);
    r.position    = 30'(ang + turn_cnt * REV_COUNTS);
    r.turns       = 16'(turn_cnt);
    r.angle_q13   = 38'(longint'(ang - zero_bias) * 360 + longint'(turn_cnt) * DEG_PER_TURN);
    r.step_rate   = 14'(step_v);
    r.filt_rate   = 14'(rate_sum / RATE_TAPS);
    r.speed       = f.speed;
    r.torque_cur  = 7'(cur_q);
    r.torque_est  = 25'(est_v);
    r.invalid     = (f.speed == 0);
    r.temperature = f.temp;
    tracker_results_q.push_back(r);
  endtask

  function automatic enc_frame_t mk_frame(frame_action_e a, int ang, int spd, int cur, int tmp);
    enc_frame_t f;
    f.action  = a;
    f.angle   = 13'(ang);
    f.speed   = 16'(spd);
    f.current = 16'(cur);
    f.temp    = 8'(tmp);
    return f;
  endfunction

  function automatic enc_frame_t random_frame();
    enc_frame_t f;
    int delta;
    int edge_vals[4] = '{-32768, 32767, 1, -1};
    f.action = ($urandom_range(99) < 3) ? ACT_RESTART : ACT_FEEDBACK;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: delta = int'($urandom_range(800)) - 400;
      6, 7:             delta = int'($urandom_range(8190)) - 4095;
      8:                delta = int'($urandom_range(8191));
      // right around the half-turn threshold
      default:          delta = ($urandom_range(1) ? HALF_REV : -HALF_REV)
                                + int'($urandom_range(2)) - 1;
    endcase
    gen_angle = (gen_angle + delta) & (REV_COUNTS - 1);
    f.angle = 13'(gen_angle);
    case ($urandom_range(9))
      0:       f.speed = 16'sd0;
      1:       f.speed = 16'(edge_vals[$urandom_range(3)]);
      default: f.speed = 16'($urandom);
    endcase
    case ($urandom_range(9))
      0, 1:    f.current = 16'(edge_vals[$urandom_range(1)]);
      default: f.current = 16'($urandom);
    endcase
    f.temp = 8'($urandom);
    return f;
  endfunction

  // sender: bursts with random gaps
  enc_frame_t cur_frame;
  int burst_left;
  int gap_left;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) track_frame(cur_frame);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (feedback_frames_q.size() != 0) begin
          cur_frame = feedback_frames_q.pop_front();
          s_axis_tdata  <= {3'b000, cur_frame.temp, cur_frame.current, cur_frame.speed,
                            cur_frame.angle};
          s_axis_tuser  <= cur_frame.action;
          s_axis_tvalid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(30);
            gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 45);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: mode follows bits [8:6] of a free-running cycle counter, one long hold-off
  logic [15:0] rx_cycle = 16'd0;
  int          hold_left;
  logic        long_hold_done = 1'b0;
  int          beats_seen;

  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 16'd1;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!long_hold_done && beats_seen >= 80) begin
      long_hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_cycle[8:6])
        3'd0, 3'd1, 3'd2: m_axis_tready <= 1'b1;
        3'd3, 3'd4:       m_axis_tready <= 1'($urandom_range(1));
        3'd5:             m_axis_tready <= (rx_cycle[1:0] == 2'd0);
        default:          m_axis_tready <= ($urandom_range(9) != 0);
      endcase
    end
  end

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  track_result_t got_res;
  track_result_t want_res;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      beats_seen <= beats_seen + 1;
      got_res = {m_axis_tuser, m_axis_tdata};
      if (tracker_results_q.size() == 0) begin
        $error("result beat with nothing expected");
        mismatches++;
      end else begin
        want_res = tracker_results_q.pop_front();
        check_field("position_count", want_res.position, got_res.position);
        check_field("turns", want_res.turns, got_res.turns);
        check_field("angle_q13", want_res.angle_q13, got_res.angle_q13);
        check_field("step_rate", want_res.step_rate, got_res.step_rate);
        check_field("filtered_rate", want_res.filt_rate, got_res.filt_rate);
        check_field("speed_out", want_res.speed, got_res.speed);
        check_field("scaled_current", want_res.torque_cur, got_res.torque_cur);
        check_field("torque_estimate", want_res.torque_est, got_res.torque_est);
        check_field("torque_invalid", want_res.invalid, got_res.invalid);
        check_field("temperature", want_res.temperature, got_res.temperature);
      end
    end
  end

  int stall_cycles;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic wait_idle();
    do @(negedge clk_i);
    while (feedback_frames_q.size() != 0 || s_axis_tvalid || tracker_results_q.size() != 0);
    // bias and restart beats give nothing back but may still be in flight
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_bias(input int v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= 8'(v);
    bias_cfg = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  int phase_bias[5];

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset bias count: capture, then the half-turn edges both ways
    feedback_frames_q.push_back(mk_frame(ACT_FEEDBACK, 100, 5, 0, 0));
    feedback_frames_q.push_back(mk_frame(ACT_FEEDBACK, 8191, -5, 100, 1));
    feedback_frames_q.push_back(mk_frame(ACT_FEEDBACK, 8191, 0, 32767, 255));
    feedback_frames_q.push_back(mk_frame(ACT_FEEDBACK, 0, -32768, -32768, 0));
    feedback_frames_q.push_back(mk_frame(ACT_FEEDBACK, 4096, 32767, 32767, 128));
    feedback_frames_q.push_back(mk_frame(ACT_FEEDBACK, 0, 1, 32767, 7));
    feedback_frames_q.push_back(mk_frame(ACT_FEEDBACK, 4097, -1, -32768, 8));
    feedback_frames_q.push_back(mk_frame(ACT_FEEDBACK, 0, 1, -32768, 9));
    feedback_frames_q.push_back(mk_frame(ACT_FEEDBACK, 8191, 0, -32768, 10));
    feedback_frames_q.push_back(mk_frame(ACT_RESTART, 1234, 0, 0, 0));
    feedback_frames_q.push_back(mk_frame(ACT_FEEDBACK, 3000, 7, 1, 2));
    feedback_frames_q.push_back(mk_frame(ACT_FEEDBACK, 3001, 8, 2, 3));
    feedback_frames_q.push_back(mk_frame(ACT_FEEDBACK, 3005, 100, 820, 50));
    wait_idle();

    // no capture at all
    write_bias(0);
    feedback_frames_q.push_back(mk_frame(ACT_FEEDBACK, 0, 32767, 1, 3));
    feedback_frames_q.push_back(mk_frame(ACT_RESTART, 8191, -1, -1, 255));
    feedback_frames_q.push_back(mk_frame(ACT_FEEDBACK, 8191, -32768, -1, 4));
    wait_idle();

    // everything is captured, frame count runs into saturation
    write_bias(255);
    repeat (260) feedback_frames_q.push_back(mk_frame(ACT_FEEDBACK, $urandom_range(8191),
                                                      $urandom, $urandom, $urandom));
    feedback_frames_q.push_back(mk_frame(ACT_RESTART, 0, 0, 0, 0));
    feedback_frames_q.push_back(mk_frame(ACT_FEEDBACK, 77, 3, 3, 3));
    wait_idle();

    write_bias(1);
    feedback_frames_q.push_back(mk_frame(ACT_FEEDBACK, 500, 10, 5000, 20));
    feedback_frames_q.push_back(mk_frame(ACT_FEEDBACK, 600, -10, -5000, 21));
    wait_idle();

    phase_bias = '{1, 2, 0, 0, 1};
    phase_bias[3] = $urandom_range(3, 9);
    foreach (phase_bias[p]) begin
      write_bias(phase_bias[p]);
      repeat (PHASE_FRAMES) feedback_frames_q.push_back(random_frame());
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
